@@ hw/rtl/grr_pkg.sv @@
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and codes for the glyph row renderer: operation codes, result
// status codes, register indexes, the command passed from front to back and
// the result item.
// ----------------------------------------------------------------------------
package grr_pkg;

  // input operation codes
  localparam logic [1:0] OP_LOAD_ENC   = 2'd0;
  localparam logic [1:0] OP_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] OP_DRAW       = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_ROW       = 3'd0;
  localparam logic [2:0] STAT_BAD_POS   = 3'd1;
  localparam logic [2:0] STAT_BAD_CODE  = 3'd2;
  localparam logic [2:0] STAT_NO_GLYPH  = 3'd3;
  localparam logic [2:0] STAT_LOAD_DONE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_SCREEN_W  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_H  = 3'd1;
  localparam logic [2:0] CFG_ENC_SIZE  = 3'd2;
  localparam logic [2:0] CFG_GLYPH_W   = 3'd3;
  localparam logic [2:0] CFG_GLYPH_H   = 3'd4;

  localparam logic [12:0] SCREEN_MAX = 13'd4096;
  localparam logic [3:0]  MAX_W      = 4'd8;
  localparam logic [4:0]  MAX_H      = 5'd16;

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [7:0]  encoding_size;
    logic [3:0]  glyph_width;
    logic [4:0]  glyph_height;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_DONE,
    CMD_LD_ENC,
    CMD_LD_GLYPH,
    CMD_BAD_POS,
    CMD_BAD_CODE,
    CMD_DRAW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] addr;
    logic [11:0] value;
    logic        absent;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  code;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        dbl;
    logic        bgw;
    logic [3:0]  w;
    logic [4:0]  h;
  } cmd_t;

  typedef struct packed {
    logic        push;
    cmd_t        cmd;
  } q_wr_t;

  typedef struct packed {
    logic [11:0] row_x;
    logic [12:0] row_y;
    logic [4:0]  span_pixels;
    logic [15:0] fg_mask;
    logic        bg_write;
    logic [15:0] out_fg;
    logic [15:0] out_bg;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_CHECK,
    BK_EMIT
  } back_state_t;

endpackage

@@ hw/rtl/grr_front.sv @@
// ----------------------------------------------------------------------------
// grr_front
// Accepts input requests, checks position and character code against the
// configuration, saturates the glyph size and turns each request into one
// command for the request queue.
// ----------------------------------------------------------------------------
module grr_front import grr_pkg::*; #(
  parameter int ENC_DEPTH   = 128,
  parameter int GLYPH_BYTES = 4096,
  parameter int COLOR_BITS  = 16
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [11:0]       table_addr,
  input  logic [11:0]       table_value,
  input  logic              glyph_absent,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [7:0] char_code,
  input  logic [15:0]       fg_color,
  input  logic [15:0]       bg_color,
  input  logic              double_scale,
  input  logic              transparent_bg,
  input  cfg_t              cfg,
  input  logic              q_full,
  output q_wr_t             q_wr
);

  localparam logic [15:0] COLOR_MASK =
    (COLOR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COLOR_BITS) - 32'd1);
  localparam logic [16:0] ENC_LIMIT   = 17'(ENC_DEPTH);
  localparam logic [16:0] GLYPH_LIMIT = 17'(GLYPH_BYTES);

  logic [12:0] sw;
  logic [12:0] sh;
  logic [15:0] px_u;
  logic [15:0] py_u;
  logic [7:0]  code_u;
  logic        bad_pos;
  logic        bad_code;
  logic        enc_in_range;
  logic        glyph_in_range;
  cmd_kind_t   kind;

  assign in_ready = !q_full;

  assign sw     = (cfg.screen_width  > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_width;
  assign sh     = (cfg.screen_height > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_height;
  assign px_u   = $unsigned(pos_x);
  assign py_u   = $unsigned(pos_y);
  assign code_u = $unsigned(char_code);

  assign bad_pos = px_u[15] || py_u[15] ||
                   (px_u >= {3'b000, sw}) || (py_u >= {3'b000, sh});
  assign bad_code = code_u[7] || (code_u >= cfg.encoding_size) ||
                    ({9'd0, code_u} >= ENC_LIMIT);

  assign enc_in_range   = {5'd0, table_addr} < ENC_LIMIT;
  assign glyph_in_range = {5'd0, table_addr} < GLYPH_LIMIT;

  always_comb begin
    unique case (op)
      OP_LOAD_ENC:   kind = enc_in_range ? CMD_LD_ENC : CMD_DONE;
      OP_LOAD_GLYPH: kind = glyph_in_range ? CMD_LD_GLYPH : CMD_DONE;
      OP_DRAW: begin
        if (bad_pos) begin
          kind = CMD_BAD_POS;
        end else if (bad_code) begin
          kind = CMD_BAD_CODE;
        end else begin
          kind = CMD_DRAW;
        end
      end
      default:       kind = CMD_DONE;
    endcase
  end

  always_comb begin
    q_wr.push       = in_valid && in_ready;
    q_wr.cmd.kind   = kind;
    q_wr.cmd.addr   = table_addr;
    q_wr.cmd.value  = table_value;
    q_wr.cmd.absent = glyph_absent;
    q_wr.cmd.px     = px_u[11:0];
    q_wr.cmd.py     = py_u[11:0];
    q_wr.cmd.code   = code_u;
    q_wr.cmd.fg     = fg_color & COLOR_MASK;
    q_wr.cmd.bg     = bg_color & COLOR_MASK;
    q_wr.cmd.dbl    = double_scale;
    q_wr.cmd.bgw    = !transparent_bg;
    q_wr.cmd.w      = (cfg.glyph_width  > MAX_W) ? MAX_W : cfg.glyph_width;
    q_wr.cmd.h      = (cfg.glyph_height > MAX_H) ? MAX_H : cfg.glyph_height;
  end

endmodule

@@ hw/rtl/grr_queue.sv @@
// ----------------------------------------------------------------------------
// grr_queue
// Short request queue between front and back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module grr_queue import grr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  output logic  q_full,
  output logic  q_valid,
  output cmd_t  q_head,
  input  logic  q_pop
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign q_full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = slots[rd_ptr];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  function automatic logic [Q_IDX_W-1:0] wrap_inc(input logic [Q_IDX_W-1:0] p);
    return (p == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/grr_back.sv @@
// ----------------------------------------------------------------------------
// grr_back
// Carries out queued commands in order: writes the encoding and glyph stores,
// looks up the glyph of a draw, folds its start offset into the glyph store
// and emits one row span per screen row into the output register.
// ----------------------------------------------------------------------------
module grr_back import grr_pkg::*; #(
  parameter int ENC_DEPTH   = 128,
  parameter int GLYPH_BYTES = 4096
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cmd_t    q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  localparam int EA_W = $clog2(ENC_DEPTH);
  localparam int GA_W = $clog2(GLYPH_BYTES);
  localparam logic [16:0]     G_SIZE = 17'(GLYPH_BYTES);
  localparam logic [GA_W-1:0] G_LAST = GA_W'(GLYPH_BYTES - 1);

  logic [12:0]          enc_mem   [ENC_DEPTH];
  logic [7:0]           glyph_mem [GLYPH_BYTES];
  logic [ENC_DEPTH-1:0] enc_valid;

  back_state_t     state;
  back_state_t     state_next;
  cmd_t            cur;
  logic [12:0]     enc_rdata;
  logic            enc_valid_r;
  logic [EA_W-1:0] enc_raddr;
  logic [EA_W-1:0] enc_waddr;
  logic            enc_we;
  logic            glyph_we;
  logic [GA_W-1:0] glyph_waddr;
  logic [7:0]      glyph_rdata;
  logic [GA_W-1:0] gaddr;
  logic [GA_W-1:0] gaddr_next;
  logic            absent_r;
  logic [16:0]     red;
  logic [3:0]      row;
  logic            sub;
  logic            fold;
  logic            row_done;
  logic            last_row;
  logic            out_free;
  logic            out_load;
  result_t         res_next;
  logic [15:0]     mask;
  logic [7:0]      mask_single;
  logic [15:0]     mask_dbl;

  assign out_free  = !out_valid || out_ready;
  assign fold      = (red >= G_SIZE);
  assign row_done  = !cur.dbl || sub;
  assign last_row  = ({1'b0, row} == (cur.h - 5'd1));
  assign enc_raddr = EA_W'(q_head.code);
  assign enc_waddr = EA_W'(q_head.addr);
  assign glyph_waddr = GA_W'(q_head.addr);

  // encoding store: one write port, registered read
  always_ff @(posedge clk) begin
    if (enc_we) begin
      enc_mem[enc_waddr] <= {q_head.absent, q_head.value};
    end
    enc_rdata <= enc_mem[enc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid   <= '0;
      enc_valid_r <= 1'b0;
    end else begin
      if (enc_we) begin
        enc_valid[enc_waddr] <= 1'b1;
      end
      enc_valid_r <= enc_valid[enc_raddr];
    end
  end

  // glyph store: read address is the next row address, data lands with it
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= q_head.value[7:0];
    end
    glyph_rdata <= glyph_mem[gaddr_next];
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask_single[j]      = glyph_rdata[7-j] && (4'(j) < cur.w);
      mask_dbl[2*j +: 2]  = {2{mask_single[j]}};
    end
    mask = cur.dbl ? mask_dbl : {8'h00, mask_single};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_pop && (q_head.kind == CMD_DRAW)) begin
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: state_next = BK_CHECK;
      BK_CHECK: begin
        if (absent_r || (cur.h == 5'd0)) begin
          if (out_free) begin
            state_next = BK_IDLE;
          end
        end else if (!fold) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && row_done && last_row) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    enc_we     = 1'b0;
    glyph_we   = 1'b0;
    out_load   = 1'b0;
    gaddr_next = gaddr;
    res_next   = '0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_valid && ((q_head.kind == CMD_DRAW) || out_free);
        enc_we   = q_pop && (q_head.kind == CMD_LD_ENC);
        glyph_we = q_pop && (q_head.kind == CMD_LD_GLYPH);
        out_load = q_pop && (q_head.kind != CMD_DRAW);
        res_next.last = 1'b1;
        unique case (q_head.kind)
          CMD_BAD_POS:  res_next.status = STAT_BAD_POS;
          CMD_BAD_CODE: res_next.status = STAT_BAD_CODE;
          default:      res_next.status = STAT_LOAD_DONE;
        endcase
      end
      BK_LOOKUP: begin
      end
      BK_CHECK: begin
        res_next.last = 1'b1;
        if (absent_r) begin
          out_load        = out_free;
          res_next.status = STAT_NO_GLYPH;
        end else if (cur.h == 5'd0) begin
          out_load        = out_free;
          res_next.status = STAT_ROW;
        end else if (!fold) begin
          gaddr_next = red[GA_W-1:0];
        end
      end
      BK_EMIT: begin
        out_load             = out_free;
        res_next.row_x       = cur.px;
        res_next.row_y       = cur.dbl ? (13'(cur.py) + 13'({row, sub}))
                                       : (13'(cur.py) + 13'(row));
        res_next.span_pixels = cur.dbl ? {cur.w, 1'b0} : {1'b0, cur.w};
        res_next.fg_mask     = mask;
        res_next.bg_write    = cur.bgw;
        res_next.out_fg      = cur.fg;
        res_next.out_bg      = cur.bg;
        res_next.status      = STAT_ROW;
        res_next.last        = row_done && last_row;
        if (out_free && row_done) begin
          gaddr_next = (gaddr == G_LAST) ? '0 : gaddr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    gaddr <= gaddr_next;
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == BK_LOOKUP) begin
      absent_r <= !enc_valid_r || enc_rdata[12];
      red      <= 17'(enc_rdata[11:0]);
    end else if ((state == BK_CHECK) && fold) begin
      red <= red - G_SIZE;
    end
    if (state == BK_CHECK) begin
      row <= '0;
      sub <= 1'b0;
    end else if ((state == BK_EMIT) && out_free) begin
      if (cur.dbl && !sub) begin
        sub <= 1'b1;
      end else begin
        sub <= 1'b0;
        row <= row + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/glyph_row_renderer_top.sv @@
// ----------------------------------------------------------------------------
// glyph_row_renderer_top
// Bitmap font character generator: load requests fill the encoding and glyph
// stores, draw requests produce one row span per screen row.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry request queue has room, so new
// requests keep coming in while results wait at the output. The back-end
// sequencer works one request at a time: a load or a rejected draw gives its
// single result in the cycle after it is popped from the head of the queue. A
// draw passes through queue pop, encoding lookup and glyph check, then gives
// one result row per screen row, that is glyph_height rows in normal size and
// twice that in double size. When GLYPH_BYTES is below 4096, folding the glyph
// start offset into the store subtracts GLYPH_BYTES from it on each pass
// through the glyph check until it is below GLYPH_BYTES. A stalled output
// holds the sequencer. Encoding entries read as absent until written; there
// is no clearing pass after reset.
module glyph_row_renderer_top import grr_pkg::*; #(
  parameter int ENC_DEPTH   = 128,
  parameter int GLYPH_BYTES = 4096,
  parameter int COLOR_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [11:0]        table_addr,
  input  logic [11:0]        table_value,
  input  logic               glyph_absent,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [7:0]  char_code,
  input  logic [15:0]        fg_color,
  input  logic [15:0]        bg_color,
  input  logic               double_scale,
  input  logic               transparent_bg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        row_x,
  output logic [12:0]        row_y,
  output logic [4:0]         span_pixels,
  output logic [15:0]        fg_mask,
  output logic               bg_write,
  output logic [15:0]        out_fg,
  output logic [15:0]        out_bg,
  output logic [2:0]         status,
  output logic               last
);

  cfg_t    cfg;
  q_wr_t   q_wr;
  logic    q_full;
  logic    q_valid;
  cmd_t    q_head;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd320;
      cfg.screen_height <= 13'd240;
      cfg.encoding_size <= 8'd128;
      cfg.glyph_width   <= 4'd8;
      cfg.glyph_height  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_W: cfg.screen_width  <= cfg_data;
        CFG_SCREEN_H: cfg.screen_height <= cfg_data;
        CFG_ENC_SIZE: cfg.encoding_size <= cfg_data[7:0];
        CFG_GLYPH_W:  cfg.glyph_width   <= cfg_data[3:0];
        CFG_GLYPH_H:  cfg.glyph_height  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  grr_front #(
    .ENC_DEPTH   (ENC_DEPTH),
    .GLYPH_BYTES (GLYPH_BYTES),
    .COLOR_BITS  (COLOR_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .table_addr     (table_addr),
    .table_value    (table_value),
    .glyph_absent   (glyph_absent),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .char_code      (char_code),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .double_scale   (double_scale),
    .transparent_bg (transparent_bg),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_wr           (q_wr)
  );

  grr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  grr_back #(
    .ENC_DEPTH   (ENC_DEPTH),
    .GLYPH_BYTES (GLYPH_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign row_x       = res.row_x;
  assign row_y       = res.row_y;
  assign span_pixels = res.span_pixels;
  assign fg_mask     = res.fg_mask;
  assign bg_write    = res.bg_write;
  assign out_fg      = res.out_fg;
  assign out_bg      = res.out_bg;
  assign status      = res.status;
  assign last        = res.last;

endmodule

@@ hw/rtl/grr_checker.sv @@
// ----------------------------------------------------------------------------
// grr_checker
// Port-level checks on the result channel of the glyph row renderer, bound
// to the top level.
// ----------------------------------------------------------------------------
module grr_checker import grr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] row_x,
  input logic [12:0] row_y,
  input logic [4:0]  span_pixels,
  input logic [15:0] fg_mask,
  input logic [2:0]  status,
  input logic        last
);

  // status results close their request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_ROW) |-> last)
    else $error("status result without last");

  // status results carry no span
  a_status_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_ROW) |->
      (row_x == 12'd0) && (row_y == 13'd0) && (span_pixels == 5'd0) && (fg_mask == 16'd0))
    else $error("status result with span fields set");

  // an empty span has an empty mask
  a_empty_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (span_pixels == 5'd0) |-> (fg_mask == 16'd0))
    else $error("mask set on empty span");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= STAT_LOAD_DONE))
    else $error("unknown status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_y) && $stable(status) && $stable(last))
    else $error("stalled result changed");

endmodule

bind glyph_row_renderer_top grr_checker u_grr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .row_x       (row_x),
  .row_y       (row_y),
  .span_pixels (span_pixels),
  .fg_mask     (fg_mask),
  .status      (status),
  .last        (last)
);
